// ----- design/uvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and rounding helpers for the UV-sphere vertex
// generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int unsigned MAX_SEGMENTS = 1024;
	localparam int unsigned SEG_W        = 11;
	localparam int unsigned RAD_W        = 15;
	localparam int unsigned ADDR_W       = 4;

	// odd Taylor terms of sin(pi/2*x), Q28
	localparam logic [29:0] COEF_A1 = 30'd421657428;
	localparam logic [29:0] COEF_A3 = 30'd173399667;
	localparam logic [29:0] COEF_A5 = 30'd21392326;
	localparam logic [29:0] COEF_A7 = 30'd1256749;
	localparam logic [29:0] COEF_A9 = 30'd43068;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	// register indexes
	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_RADIUS  = 2'd2;

	typedef struct packed {
		logic [SEG_W-1:0] columns_in_use;
		logic [SEG_W-1:0] rows_in_use;
		logic [RAD_W-1:0] sphere_radius;
	} cfg_t;

	// zero acts as one, above the maximum acts as the maximum
	function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] s);
		logic [SEG_W-1:0] r;
		if (s == '0)
			r = SEG_W'(1);
		else if (s > SEG_W'(MAX_SEGMENTS))
			r = SEG_W'(MAX_SEGMENTS);
		else
			r = s;
		return r;
	endfunction

	// shift right, round half away from zero, saturate to 16 bits
	function automatic logic [15:0] rnd_sat(input logic signed [47:0] v,
	                                        input int unsigned sh);
		logic [48:0] mag;
		logic [48:0] rs;
		logic [15:0] r;
		mag = v[47] ? (~{v[47], v} + 49'd1) : {1'b0, v};
		rs  = (mag + (49'd1 << (sh - 1))) >> sh;
		if (v[47]) begin
			if (rs > 49'd32768)
				r = 16'h8000;
			else
				r = 16'(16'd0 - rs[15:0]);
		end else begin
			if (rs > 49'd32767)
				r = 16'h7FFF;
			else
				r = rs[15:0];
		end
		return r;
	endfunction

endpackage

// ----- design/uvs_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_regs
// APB register file: segment counts and sphere radius.
// ----------------------------------------------------------------------------
module uvs_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uvs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output uvs_pkg::cfg_t              cfg
);
	import uvs_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx = paddr[3:2];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns_in_use <= SEG_W'(32);
			cfg_q.rows_in_use    <= SEG_W'(16);
			cfg_q.sphere_radius  <= RAD_W'(256);
		end else if (wr) begin
			unique case (idx)
				REG_COLUMNS: cfg_q.columns_in_use <= pwdata[SEG_W-1:0];
				REG_ROWS:    cfg_q.rows_in_use    <= pwdata[SEG_W-1:0];
				REG_RADIUS:  cfg_q.sphere_radius  <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COLUMNS: prdata = 32'(cfg_q.columns_in_use);
			REG_ROWS:    prdata = 32'(cfg_q.rows_in_use);
			REG_RADIUS:  prdata = 32'(cfg_q.sphere_radius);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- design/uvs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider: q = round(idx/seg) in Q1.15, four quotient
// bits per stage, four stages.
// ----------------------------------------------------------------------------
module uvs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [uvs_pkg::SEG_W-1:0] idx,
	input  logic [uvs_pkg::SEG_W-1:0] seg,
	output logic                      out_valid,
	output logic [15:0]               quo
);
	import uvs_pkg::*;

	// dividend = idx*65536 + seg, divisor = 2*seg; the high part (idx) is
	// already below the divisor, so only the low 16 bits are shifted in
	logic [11:0] rem_s [4];
	logic [15:0] quo_s [4];
	logic        vld_s [4];
	logic [11:0] rem_n [4];
	logic [15:0] quo_n [4];
	logic [15:0] low;
	logic [11:0] dsr;
	logic [11:0] rem_in;

	assign low    = 16'(seg);
	assign dsr    = {seg, 1'b0};
	assign rem_in = (idx > seg) ? 12'(seg) : 12'(idx);

	always_comb begin
		logic [11:0] r;
		logic [15:0] qq;
		logic [12:0] t;
		for (int k = 0; k < 4; k++) begin
			r  = (k == 0) ? rem_in : rem_s[(k == 0) ? 0 : k - 1];
			qq = (k == 0) ? 16'd0  : quo_s[(k == 0) ? 0 : k - 1];
			for (int j = 0; j < 4; j++) begin
				t = {r, low[15 - (4 * k + j)]};
				if (t >= 13'(dsr)) begin
					r  = 12'(t - 13'(dsr));
					qq = {qq[14:0], 1'b1};
				end else begin
					r  = t[11:0];
					qq = {qq[14:0], 1'b0};
				end
			end
			rem_n[k] = r;
			quo_n[k] = qq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < 4; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end

	assign out_valid = vld_s[3];
	assign quo       = quo_s[3];

endmodule

// ----- design/uvs_sine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sine
// Pipelined sine of a 16-bit phase, Q1.14 result. Quadrant fold, square,
// four Horner steps, final multiply, round and sign: eight stages.
// ----------------------------------------------------------------------------
module uvs_sine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] phase,
	output logic        out_valid,
	output logic [15:0] val
);
	import uvs_pkg::*;

	logic [7:0]  vld_s;
	logic [1:0]  q_s  [7];
	logic [16:0] x_s  [7];
	logic [16:0] z_s  [4];
	logic [29:0] p_s  [4];
	logic [29:0] s_s7;
	logic [15:0] val_s8;

	logic [16:0] x0;
	logic [33:0] xx;
	logic [46:0] pz  [4];
	logic [29:0] a_k [4];
	logic [46:0] px;
	logic [16:0] mr;
	logic [14:0] m;

	assign x0 = phase[14] ? (17'h10000 - {1'b0, phase[13:0], 2'b00})
	                      : {1'b0, phase[13:0], 2'b00};
	assign xx = x_s[0] * x_s[0];

	assign a_k[0] = COEF_A7;
	assign a_k[1] = COEF_A5;
	assign a_k[2] = COEF_A3;
	assign a_k[3] = COEF_A1;

	// z travels with each Horner step
	always_comb begin
		pz[0] = COEF_A9 * z_s[0];
		for (int k = 1; k < 4; k++) pz[k] = p_s[k-1] * z_s[k];
	end

	assign px = p_s[3] * x_s[5];
	assign mr = 17'((s_s7 + 30'd8192) >> 14);
	assign m  = (mr > 17'd16384) ? 15'd16384 : mr[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[6:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= phase[15:14];
			x_s[0] <= x0;
			for (int k = 1; k < 7; k++) begin
				q_s[k] <= q_s[k-1];
				x_s[k] <= x_s[k-1];
			end
			z_s[0] <= 17'((xx + 34'd32768) >> 16);
			for (int k = 1; k < 4; k++)
				z_s[k] <= z_s[k-1];
			for (int k = 0; k < 4; k++)
				p_s[k] <= a_k[k] - 30'((pz[k] + 47'd32768) >> 16);
			s_s7   <= 30'((px + 47'd32768) >> 16);
			val_s8 <= q_s[6][1] ? 16'(16'd0 - {1'b0, m}) : {1'b0, m};
		end
	end

	assign out_valid = vld_s[7];
	assign val       = val_s8;

endmodule

// ----- design/uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Grid point (column, row) in, UV-sphere vertex out: position, normal,
// tangent, bitangent and texture coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one grid point per transaction; m_axis returns one vertex
//   per transaction, in order. Segment counts and radius are set over APB
//   (0x0 columns, 0x4 rows, 0x8 radius) while no transaction is in flight.
//   Throughput: one vertex per clock unless the receiver stalls. A grid point
//   passes the input register, loaded at the accepting edge, then 4 divider
//   stages, 8 sine stages, 3 product/rounding stages and the output register.
//   When the receiver stalls, the output register holds its vertex and one
//   more goes into a skid register; s_axis_tready is then dropped and the
//   whole pipeline freezes, so nothing is lost or repeated.
//   Reset (arst_n low) clears all valid bits and loads the registers with
//   32 columns, 16 rows and radius 1.0.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [23:0]                s_axis_tdata,  // column[10:0], row[21:11]
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// position_xyz[47:0], normal_xyz[95:48], tangent_xyz[143:96],
	// bitangent_xyz[191:144], tex_uv[223:192]
	output logic [223:0]               m_axis_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uvs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import uvs_pkg::*;

	cfg_t             cfg;
	logic             en;
	logic [SEG_W-1:0] cols, rows;

	logic             v_s1;
	logic [SEG_W-1:0] col_s1, row_s1;

	logic             u_vld, v_vld;
	logic [15:0]      u_q15, v_q15;
	logic [15:0]      tph;
	logic             sv [4];
	logic [15:0]      st, ct, sp, cp;

	logic [31:0]      uv_d [8];

	logic                v_p1;
	logic signed [31:0]  ctsp_p1, stsp_p1, ctcp_p1, stcp_p1;
	logic [15:0]         st_p1, ct_p1, sp_p1, cp_p1;
	logic [31:0]         uv_p1;

	logic                v_p2;
	logic signed [47:0]  posx_p2, posz_p2;
	logic signed [31:0]  posy_p2;
	logic [127:0]        rest_p2;  // normal x/z, tangent, bitangent
	logic [15:0]         cp_p2;
	logic [31:0]         uv_p2;

	logic                v_p3;
	logic [223:0]        item_p3;

	logic                out_v_q, skid_v_q;
	logic [223:0]        out_q, skid_q;

	assign pready = 1'b1;

	uvs_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	assign cols = clamp_seg(cfg.columns_in_use);
	assign rows = clamp_seg(cfg.rows_in_use);

	// pipeline advances unless the skid register is occupied
	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= s_axis_tdata[10:0];
			row_s1 <= s_axis_tdata[21:11];
		end
	end

	uvs_div u_div_u (
		.clk, .arst_n, .en, .in_valid(v_s1), .idx(col_s1), .seg(cols),
		.out_valid(u_vld), .quo(u_q15)
	);

	uvs_div u_div_v (
		.clk, .arst_n, .en, .in_valid(v_s1), .idx(row_s1), .seg(rows),
		.out_valid(v_vld), .quo(v_q15)
	);

	assign tph = {u_q15[14:0], 1'b0};

	uvs_sine u_sin_t (
		.clk, .arst_n, .en, .in_valid(u_vld), .phase(tph),
		.out_valid(sv[0]), .val(st)
	);

	uvs_sine u_cos_t (
		.clk, .arst_n, .en, .in_valid(u_vld), .phase(16'(tph + QUARTER_TURN)),
		.out_valid(sv[1]), .val(ct)
	);

	uvs_sine u_sin_p (
		.clk, .arst_n, .en, .in_valid(v_vld), .phase(v_q15),
		.out_valid(sv[2]), .val(sp)
	);

	uvs_sine u_cos_p (
		.clk, .arst_n, .en, .in_valid(v_vld), .phase(16'(v_q15 + QUARTER_TURN)),
		.out_valid(sv[3]), .val(cp)
	);

	// texture coordinates ride alongside the sine pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			uv_d[0] <= {u_q15, v_q15};
			for (int k = 1; k < 8; k++) uv_d[k] <= uv_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= sv[0] & sv[1] & sv[2] & sv[3];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// P1: pairwise products, Q28
			ctsp_p1 <= $signed(ct) * $signed(sp);
			stsp_p1 <= $signed(st) * $signed(sp);
			ctcp_p1 <= $signed(ct) * $signed(cp);
			stcp_p1 <= $signed(st) * $signed(cp);
			st_p1   <= st;
			ct_p1   <= ct;
			sp_p1   <= sp;
			cp_p1   <= cp;
			uv_p1   <= uv_d[7];

			// P2: radius scaling, unit vectors rounded
			posx_p2 <= ctsp_p1 * $signed({1'b0, cfg.sphere_radius});
			posz_p2 <= stsp_p1 * $signed({1'b0, cfg.sphere_radius});
			posy_p2 <= $signed(cp_p1) * $signed({1'b0, cfg.sphere_radius});
			rest_p2 <= {
				rnd_sat(48'(ctcp_p1), 14), 16'(16'd0 - sp_p1), rnd_sat(48'(stcp_p1), 14),
				16'(16'd0 - st_p1), 16'd0, ct_p1,
				rnd_sat(48'(ctsp_p1), 14), rnd_sat(48'(stsp_p1), 14)
			};
			cp_p2   <= cp_p1;
			uv_p2   <= uv_p1;

			// P3: position to Q7.8, pack
			item_p3 <= {
				uv_p2,
				rest_p2[127:32],
				rest_p2[31:16], cp_p2, rest_p2[15:0],
				rnd_sat(posx_p2, 28), rnd_sat(48'(posy_p2), 14), rnd_sat(posz_p2, 28)
			};
		end
	end

	// output register plus skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_axis_tready) begin
			if (en && v_p3)
				skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_axis_tready) begin
			if (en && v_p3)
				skid_q <= item_p3;
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= item_p3;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule
